### rtl/vora_pkg.sv
package vora_pkg;

    localparam int BUFFER_BYTES = 4096;
    localparam int HEADER_BYTES = 2;
    localparam int PTR_W        = 13;
    localparam int CNT_W        = 12;
    localparam int LINK_DEPTH   = BUFFER_BYTES / 2;
    localparam int LINK_AW      = $clog2(LINK_DEPTH);
    localparam int LINK_W       = LINK_AW + 1;
    localparam int CFG_AW       = 3;

    localparam logic [PTR_W-1:0] EVEN_MASK = 13'h1FFE;
    localparam logic [PTR_W-1:0] CAP_MAX   = PTR_W'(BUFFER_BYTES);
    localparam logic [CNT_W-1:0] COUNT_MAX = 12'hFFF;

    localparam logic [0:0] REG_CAPACITY = 1'b0;

    typedef enum logic [1:0] {
        FUNC_ALLOC = 2'd0,
        FUNC_POP   = 2'd1,
        FUNC_PEEK  = 2'd2,
        FUNC_CLEAR = 2'd3
    } t_func;

    typedef struct packed {
        logic [PTR_W-1:0] free_bytes;
        logic [PTR_W-1:0] used_bytes;
        logic             is_full;
    } t_status;

    typedef struct packed {
        logic             ok;
        logic [PTR_W-1:0] data_offset;
        logic [PTR_W-1:0] free_bytes;
        logic [PTR_W-1:0] used_bytes;
        logic [CNT_W-1:0] object_count;
        logic             is_empty;
        logic             is_full;
    } t_result;

endpackage

### rtl/vora_if.sv
interface vora_req_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                func;
    logic [vora_pkg::CNT_W-1:0] obj_size;

    modport source (output valid, output func, output obj_size, input ready);
    modport sink   (input valid, input func, input obj_size, output ready);
endinterface

interface vora_rsp_if;
    logic                       valid;
    logic                       ready;
    logic                       ok;
    logic [vora_pkg::PTR_W-1:0] data_offset;
    logic [vora_pkg::PTR_W-1:0] free_bytes;
    logic [vora_pkg::PTR_W-1:0] used_bytes;
    logic [vora_pkg::CNT_W-1:0] object_count;
    logic                       is_empty;
    logic                       is_full;

    modport source (output valid, output ok, output data_offset, output free_bytes,
                    output used_bytes, output object_count, output is_empty,
                    output is_full, input ready);
    modport sink   (input valid, input ok, input data_offset, input free_bytes,
                    input used_bytes, input object_count, input is_empty,
                    input is_full, output ready);
endinterface

### rtl/vora_cfg.sv
module vora_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [vora_pkg::CFG_AW-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output logic [vora_pkg::PTR_W-1:0]    o_capacity
);

    logic [vora_pkg::PTR_W-1:0] r_capacity;
    logic [vora_pkg::PTR_W-1:0] n_capacity;
    logic [vora_pkg::PTR_W-1:0] wr_val;
    logic                       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == vora_pkg::REG_CAPACITY);
    assign wr_val = pwdata[vora_pkg::PTR_W-1:0];

    // limit to the ring size and force even
    always_comb begin
        n_capacity = r_capacity;
        if (wr_en) begin
            if (wr_val > vora_pkg::CAP_MAX) begin
                n_capacity = vora_pkg::CAP_MAX & vora_pkg::EVEN_MASK;
            end else begin
                n_capacity = wr_val & vora_pkg::EVEN_MASK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= vora_pkg::CAP_MAX & vora_pkg::EVEN_MASK;
        end else begin
            r_capacity <= n_capacity;
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == vora_pkg::REG_CAPACITY) begin
            prdata = {{(32-vora_pkg::PTR_W){1'b0}}, r_capacity};
        end
    end

    assign o_capacity = r_capacity;

endmodule

### rtl/vora_stat.sv
module vora_stat (
    input  logic [vora_pkg::PTR_W-1:0] i_capacity,
    input  logic [vora_pkg::PTR_W-1:0] i_write_ptr,
    input  logic [vora_pkg::PTR_W-1:0] i_read_ptr,
    input  logic [vora_pkg::CNT_W-1:0] i_count,
    output vora_pkg::t_status          o_status
);

    localparam int SW = vora_pkg::PTR_W + 2;

    logic signed [SW-1:0]        wrap_rw;   // c + r - w
    logic signed [SW-1:0]        wrap_wr;   // c + w - r
    logic [vora_pkg::PTR_W-1:0]  diff_rw;   // r - w
    logic [vora_pkg::PTR_W-1:0]  diff_wr;   // w - r
    logic [vora_pkg::PTR_W-1:0]  free_b;
    logic [vora_pkg::PTR_W-1:0]  used_b;

    assign wrap_rw = signed'(SW'(i_capacity)) + signed'(SW'(i_read_ptr))
                   - signed'(SW'(i_write_ptr));
    assign wrap_wr = signed'(SW'(i_capacity)) + signed'(SW'(i_write_ptr))
                   - signed'(SW'(i_read_ptr));
    assign diff_rw = i_read_ptr - i_write_ptr;
    assign diff_wr = i_write_ptr - i_read_ptr;

    always_comb begin
        if (i_read_ptr == i_write_ptr) begin
            free_b = (i_count == '0) ? i_capacity : '0;
            used_b = (i_count == '0) ? '0 : i_capacity;
        end else if (i_read_ptr < i_write_ptr) begin
            // wrapped sum stays below capacity, only the low side needs a limit
            free_b = (wrap_rw < 0) ? '0 : wrap_rw[vora_pkg::PTR_W-1:0];
            used_b = (diff_wr > i_capacity) ? i_capacity : diff_wr;
        end else begin
            free_b = (diff_rw > i_capacity) ? i_capacity : diff_rw;
            used_b = (wrap_wr < 0) ? '0 : wrap_wr[vora_pkg::PTR_W-1:0];
        end
    end

    assign o_status.free_bytes = free_b;
    assign o_status.used_bytes = used_b;
    assign o_status.is_full    = free_b < vora_pkg::PTR_W'(vora_pkg::HEADER_BYTES);

endmodule

### rtl/vora_core.sv
module vora_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [vora_pkg::PTR_W-1:0] i_capacity,
    vora_req_if.sink                   i_req,
    vora_rsp_if.source                 o_rsp
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    localparam int PW = vora_pkg::PTR_W;
    localparam int CW = vora_pkg::CNT_W;

    t_state                     r_state, n_state;
    logic [1:0]                 r_func;
    logic [CW-1:0]              r_size;
    logic [PW-1:0]              r_write_ptr, n_write_ptr;
    logic [PW-1:0]              r_read_ptr, n_read_ptr;
    logic [CW-1:0]              r_count, n_count;
    logic [PW-1:0]              r_last_blk, n_last_blk;
    vora_pkg::t_result          r_out, n_out;
    logic                       r_out_valid, n_out_valid;

    // link memory, one entry per even byte offset
    logic [vora_pkg::LINK_W-1:0] link_mem [vora_pkg::LINK_DEPTH];
    logic [vora_pkg::LINK_W-1:0] r_link_q;
    logic                        link_we;
    logic [vora_pkg::LINK_AW-1:0] link_waddr;
    logic [vora_pkg::LINK_W-1:0]  link_wdata;

    logic                       req_take;
    logic                       exec_done;
    logic [PW:0]                need_raw;
    logic [PW-1:0]              need;
    logic [PW:0]                wp_end;
    logic                       fits;
    logic [PW-1:0]              blk;
    logic                       ok;
    logic [PW-1:0]              offset;
    vora_pkg::t_status          stat;

    assign i_req.ready = (r_state == S_IDLE);
    assign req_take    = i_req.valid && i_req.ready;
    assign exec_done   = (r_state == S_EXEC) && (!r_out_valid || o_rsp.ready);

    always_ff @(posedge i_clk) begin
        if (link_we) begin
            link_mem[link_waddr] <= link_wdata;
        end
        // head link is fetched while the transaction is taken
        if (req_take) begin
            r_link_q <= link_mem[r_read_ptr[vora_pkg::LINK_AW:1]];
        end
    end

    assign need_raw = (PW+1)'(r_size) + (PW+1)'(vora_pkg::HEADER_BYTES + 1);
    assign need     = need_raw[PW-1:0] & vora_pkg::EVEN_MASK;
    assign wp_end   = {1'b0, r_write_ptr} + {1'b0, need};

    always_comb begin
        fits = 1'b0;
        blk  = '0;
        if (r_count >= vora_pkg::COUNT_MAX) begin
            fits = 1'b0;
        end else if (r_count == '0) begin
            fits = need <= i_capacity;
        end else if (r_write_ptr <= r_read_ptr) begin
            blk  = r_write_ptr;
            fits = wp_end <= {1'b0, r_read_ptr};
        end else if (wp_end <= {1'b0, i_capacity}) begin
            blk  = r_write_ptr;
            fits = 1'b1;
        end else if (need <= r_read_ptr) begin
            // wrap to the ring start
            fits = 1'b1;
        end
    end

    always_comb begin
        n_write_ptr = r_write_ptr;
        n_read_ptr  = r_read_ptr;
        n_count     = r_count;
        n_last_blk  = r_last_blk;
        ok          = 1'b0;
        offset      = '0;
        link_we     = 1'b0;
        link_waddr  = r_last_blk[vora_pkg::LINK_AW:1];
        link_wdata  = blk[vora_pkg::LINK_W-1:0];
        unique case (vora_pkg::t_func'(r_func))
            vora_pkg::FUNC_ALLOC: begin
                if (fits) begin
                    if (r_count == '0) begin
                        n_read_ptr = blk;
                    end else begin
                        link_we = exec_done;
                    end
                    n_count     = r_count + CW'(1);
                    n_last_blk  = blk;
                    n_write_ptr = blk + need;
                    ok          = 1'b1;
                    offset      = blk + PW'(vora_pkg::HEADER_BYTES);
                end
            end
            vora_pkg::FUNC_POP: begin
                if (r_count != '0) begin
                    ok      = 1'b1;
                    offset  = r_read_ptr + PW'(vora_pkg::HEADER_BYTES);
                    n_count = r_count - CW'(1);
                    if (r_count == CW'(1)) begin
                        n_read_ptr = r_write_ptr;
                    end else begin
                        n_read_ptr = PW'(r_link_q);
                    end
                end
            end
            vora_pkg::FUNC_PEEK: begin
                if (r_count != '0) begin
                    ok     = 1'b1;
                    offset = r_read_ptr + PW'(vora_pkg::HEADER_BYTES);
                end
            end
            vora_pkg::FUNC_CLEAR: begin
                n_write_ptr = '0;
                n_read_ptr  = '0;
                n_count     = '0;
                ok          = 1'b1;
            end
            default: begin
            end
        endcase
    end

    vora_stat u_stat (
        .i_capacity  (i_capacity),
        .i_write_ptr (n_write_ptr),
        .i_read_ptr  (n_read_ptr),
        .i_count     (n_count),
        .o_status    (stat)
    );

    always_comb begin
        n_state     = r_state;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (req_take) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (exec_done) begin
                    n_state                = S_IDLE;
                    n_out_valid            = 1'b1;
                    n_out.ok               = ok;
                    n_out.data_offset      = offset;
                    n_out.free_bytes       = stat.free_bytes;
                    n_out.used_bytes       = stat.used_bytes;
                    n_out.object_count     = n_count;
                    n_out.is_empty         = (n_count == '0);
                    n_out.is_full          = stat.is_full;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_write_ptr <= '0;
            r_read_ptr  <= '0;
            r_count     <= '0;
            r_last_blk  <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (exec_done) begin
                r_write_ptr <= n_write_ptr;
                r_read_ptr  <= n_read_ptr;
                r_count     <= n_count;
                r_last_blk  <= n_last_blk;
            end
        end
        if (req_take) begin
            r_func <= i_req.func;
            r_size <= i_req.obj_size;
        end
        r_out <= n_out;
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.ok           = r_out.ok;
    assign o_rsp.data_offset  = r_out.data_offset;
    assign o_rsp.free_bytes   = r_out.free_bytes;
    assign o_rsp.used_bytes   = r_out.used_bytes;
    assign o_rsp.object_count = r_out.object_count;
    assign o_rsp.is_empty     = r_out.is_empty;
    assign o_rsp.is_full      = r_out.is_full;

endmodule

### rtl/variable_object_ring_allocator.sv
// channel   | dir | handshake     | payload
// i_req     | in  | valid/ready   | func, obj_size
// o_rsp     | out | valid/ready   | ok, data_offset, free_bytes, used_bytes,
//           |     |               | object_count, is_empty, is_full
// apb       | in  | psel/penable  | capacity_bytes at byte address 0
//
// each transaction is taken in S_IDLE, which reads the link memory at the head
// block; S_EXEC then updates pointers and writes the link of the last block.
// a finished result sits in the output register, so the next transaction is
// taken while it waits; a stalled output holds S_EXEC until it drains.
// synchronous active-low reset clears pointers and count; capacity resets to 4096.
// the link memory has no reset, every entry is written before its value is used.
module variable_object_ring_allocator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    vora_req_if.sink                    i_req,
    vora_rsp_if.source                  o_rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [vora_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    logic [vora_pkg::PTR_W-1:0] capacity;

    vora_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_capacity (capacity)
    );

    vora_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_capacity (capacity),
        .i_req      (i_req),
        .o_rsp      (o_rsp)
    );

endmodule
